// ===== design/point_in_convex_areas_macros.svh =====
//------------------------------------------------------------------------------
// point_in_convex_areas assertion macros
// Clocked assertion helpers shared by the checker.
//------------------------------------------------------------------------------
`ifndef POINT_IN_CONVEX_AREAS_MACROS_SVH
`define POINT_IN_CONVEX_AREAS_MACROS_SVH

// Clocked property, checked outside reset.
`define PICA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, checked outside reset.
`define PICA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/pica_pkg.sv =====
//------------------------------------------------------------------------------
// pica_pkg
// Shared types, field layout and defaults for the point in convex areas block.
//------------------------------------------------------------------------------
package pica_pkg;

    localparam int DEF_MAX_AREAS    = 4;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_COORD_BITS   = 16;

    localparam int AREA_IDX_BITS = 2;
    localparam int VERT_IDX_BITS = 4;
    localparam int IN_COORD_BITS = 16;
    localparam int COUNT_W       = 5;
    localparam int CFG_W         = 3;
    localparam int MIN_VERTS     = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam int AREA_LSB = 0;
    localparam int VERT_LSB = AREA_LSB + AREA_IDX_BITS;
    localparam int X_LSB    = VERT_LSB + VERT_IDX_BITS;
    localparam int Y_LSB    = X_LSB + IN_COORD_BITS;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_FETCH,
        ST_LATCH,
        ST_MUL_A,
        ST_MUL_B,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic mul_a;
        logic mul_b;
    } xp_ctrl_t;

    typedef struct packed {
        logic zero;
        logic neg;
    } xp_stat_t;

endpackage

// ===== design/pica_vstore.sv =====
//------------------------------------------------------------------------------
// pica_vstore
// Vertex memory: one write port, one registered read port.
//------------------------------------------------------------------------------
module pica_vstore #(
    parameter int DEPTH  = pica_pkg::DEF_MAX_AREAS * pica_pkg::DEF_MAX_VERTICES,
    parameter int WIDTH  = 2 * pica_pkg::DEF_COORD_BITS,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/pica_xprod.sv =====
//------------------------------------------------------------------------------
// pica_xprod
// Shared multiplier: edge cross product over two passes, then sign compare.
//------------------------------------------------------------------------------
module pica_xprod #(
    parameter int COORD_BITS = pica_pkg::DEF_COORD_BITS
) (
    input  logic                         clk,
    input  pica_pkg::xp_ctrl_t           ctrl,
    input  logic signed [COORD_BITS-1:0] prev_x,
    input  logic signed [COORD_BITS-1:0] prev_y,
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    output pica_pkg::xp_stat_t           stat
);

    localparam int D_W = COORD_BITS + 1;
    localparam int P_W = 2 * D_W;

    logic signed [D_W-1:0] op_a;
    logic signed [D_W-1:0] op_b;
    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] prod_a_reg;
    logic signed [P_W-1:0] prod_b_reg;
    logic signed [P_W:0]   diff;

    always_comb
    begin
        if (ctrl.mul_b)
        begin
            op_a = D_W'(cur_y) - D_W'(prev_y);
            op_b = D_W'(pt_x) - D_W'(prev_x);
        end
        else
        begin
            op_a = D_W'(cur_x) - D_W'(prev_x);
            op_b = D_W'(pt_y) - D_W'(prev_y);
        end
        prod = op_a * op_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_a)
        begin
            prod_a_reg <= prod;
        end
        if (ctrl.mul_b)
        begin
            prod_b_reg <= prod;
        end
    end

    assign diff      = (P_W + 1)'(prod_a_reg) - (P_W + 1)'(prod_b_reg);
    assign stat.zero = (diff == '0);
    assign stat.neg  = diff[P_W];

endmodule

// ===== design/point_in_convex_areas.sv =====
//------------------------------------------------------------------------------
// point_in_convex_areas
// Load item: written at acceptance; input stays ready, next item taken the cycle after.
// Test item: input held not ready while active areas are scanned in order; an area
//   under three vertices is skipped, a failing edge drops an area and a hit ends the
//   scan. Input is ready again as the result is registered, held while output stalls.
// Reset clears area counts, area_count and control; vertex memory is not reset.
//------------------------------------------------------------------------------
module point_in_convex_areas #(
    parameter int MAX_AREAS    = pica_pkg::DEF_MAX_AREAS,
    parameter int MAX_VERTICES = pica_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pica_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // area_index, vertex_index, coord_x, coord_y, zero pad
    input  logic [pica_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [0:0]                     s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit, zero pad
    output logic [pica_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pica_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DEPTH      = MAX_AREAS * MAX_VERTICES;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VERT_W     = $clog2(MAX_VERTICES);
    localparam int AREA_W     = $clog2(MAX_AREAS + 1);
    localparam int AREA_IDX_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int CW         = pica_pkg::COUNT_W;

    pica_pkg::state_t state_reg, state_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [VERT_W-1:0] vidx_reg, vidx_next;
    logic closing_reg, closing_next;
    logic edge0_reg, edge0_next;
    logic sign_reg, sign_next;
    logic found_reg, found_next;
    logic m_valid_reg, m_valid_next;
    logic hit_reg, hit_next;
    logic [pica_pkg::CFG_W-1:0] area_count_reg;
    logic [CW-1:0] cnt_reg [MAX_AREAS];

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;

    logic                        s_acc;
    logic [pica_pkg::AREA_IDX_BITS-1:0] in_area;
    logic [pica_pkg::VERT_IDX_BITS-1:0] in_vert;
    logic signed [pica_pkg::IN_COORD_BITS-1:0] in_x, in_y;
    logic                        load_ok;
    logic [ADDR_W-1:0]           wr_addr, rd_addr;
    logic [2*COORD_BITS-1:0]     wr_data, rd_data;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [CW-1:0]               cur_cnt;
    logic                        area_end;
    logic                        vidx_last;
    pica_pkg::xp_ctrl_t          xp_ctrl;
    pica_pkg::xp_stat_t          xp_stat;

    assign in_area = s_tdata[pica_pkg::AREA_LSB +: pica_pkg::AREA_IDX_BITS];
    assign in_vert = s_tdata[pica_pkg::VERT_LSB +: pica_pkg::VERT_IDX_BITS];
    assign in_x    = s_tdata[pica_pkg::X_LSB +: pica_pkg::IN_COORD_BITS];
    assign in_y    = s_tdata[pica_pkg::Y_LSB +: pica_pkg::IN_COORD_BITS];

    assign s_tready  = (state_reg == pica_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(pica_pkg::M_TDATA_W - 1){1'b0}}, hit_reg};

    assign load_ok = s_acc && (s_tuser[0] == pica_pkg::KIND_LOAD)
                     && (32'(in_area) < MAX_AREAS) && (32'(in_vert) < MAX_VERTICES);
    assign wr_addr = ADDR_W'(32'(in_area) * MAX_VERTICES + 32'(in_vert));
    assign wr_data = {COORD_BITS'(in_y), COORD_BITS'(in_x)};
    assign rd_addr = ADDR_W'(32'(area_reg) * MAX_VERTICES + 32'(vidx_reg));
    assign rd_x    = rd_data[COORD_BITS-1:0];
    assign rd_y    = rd_data[2*COORD_BITS-1:COORD_BITS];

    assign cur_cnt   = cnt_reg[area_reg[AREA_IDX_W-1:0]];
    assign area_end  = (32'(area_reg) >= MAX_AREAS)
                       || (32'(area_reg) >= 32'(area_count_reg));
    assign vidx_last = (32'(vidx_reg) + 1 == 32'(cur_cnt));

    pica_vstore #(
        .DEPTH  (DEPTH),
        .WIDTH  (2 * COORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_vstore (
        .clk     (clk),
        .wr_en   (load_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pica_xprod #(
        .COORD_BITS (COORD_BITS)
    ) u_xprod (
        .clk    (clk),
        .ctrl   (xp_ctrl),
        .prev_x (prev_x_reg),
        .prev_y (prev_y_reg),
        .cur_x  (cur_x_reg),
        .cur_y  (cur_y_reg),
        .pt_x   (px_reg),
        .pt_y   (py_reg),
        .stat   (xp_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pica_pkg::ST_IDLE;
            area_reg       <= '0;
            vidx_reg       <= '0;
            closing_reg    <= 1'b0;
            edge0_reg      <= 1'b0;
            sign_reg       <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            area_count_reg <= '0;
            for (int i = 0; i < MAX_AREAS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            area_reg    <= area_next;
            vidx_reg    <= vidx_next;
            closing_reg <= closing_next;
            edge0_reg   <= edge0_next;
            sign_reg    <= sign_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            hit_reg     <= hit_next;
            if (cfg_valid && cfg_ready)
            begin
                area_count_reg <= cfg_data;
            end
            if (load_ok && s_tlast)
            begin
                cnt_reg[AREA_IDX_W'(in_area)] <= CW'(32'(in_vert) + 1);
            end
        end
    end

    // hold point and edge endpoints
    always_ff @(posedge clk)
    begin
        if (s_acc && (s_tuser[0] == pica_pkg::KIND_TEST))
        begin
            px_reg <= COORD_BITS'(in_x);
            py_reg <= COORD_BITS'(in_y);
        end
        if (state_reg == pica_pkg::ST_LATCH)
        begin
            if (vidx_reg == '0)
            begin
                first_x_reg <= rd_x;
                first_y_reg <= rd_y;
                prev_x_reg  <= rd_x;
                prev_y_reg  <= rd_y;
            end
            else
            begin
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
            end
        end
        if (state_reg == pica_pkg::ST_CMP)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            if (vidx_last)
            begin
                cur_x_reg <= first_x_reg;
                cur_y_reg <= first_y_reg;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        area_next    = area_reg;
        vidx_next    = vidx_reg;
        closing_next = closing_reg;
        edge0_next   = edge0_reg;
        sign_next    = sign_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_tready;
        hit_next     = hit_reg;
        xp_ctrl      = '0;

        unique case (state_reg)
            pica_pkg::ST_IDLE:
            begin
                if (s_acc && (s_tuser[0] == pica_pkg::KIND_TEST))
                begin
                    area_next  = '0;
                    found_next = 1'b0;
                    state_next = pica_pkg::ST_AREA;
                end
            end
            pica_pkg::ST_AREA:
            begin
                if (area_end)
                begin
                    state_next = pica_pkg::ST_DONE;
                end
                else if (32'(cur_cnt) < pica_pkg::MIN_VERTS)
                begin
                    area_next = area_reg + 1'b1;
                end
                else
                begin
                    vidx_next    = '0;
                    closing_next = 1'b0;
                    edge0_next   = 1'b1;
                    state_next   = pica_pkg::ST_FETCH;
                end
            end
            pica_pkg::ST_FETCH:
            begin
                state_next = pica_pkg::ST_LATCH;
            end
            pica_pkg::ST_LATCH:
            begin
                if (vidx_reg == '0)
                begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = pica_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = pica_pkg::ST_MUL_A;
                end
            end
            pica_pkg::ST_MUL_A:
            begin
                xp_ctrl.mul_a = 1'b1;
                state_next    = pica_pkg::ST_MUL_B;
            end
            pica_pkg::ST_MUL_B:
            begin
                xp_ctrl.mul_b = 1'b1;
                state_next    = pica_pkg::ST_CMP;
            end
            pica_pkg::ST_CMP:
            begin
                if (xp_stat.zero || (!edge0_reg && (xp_stat.neg != sign_reg)))
                begin
                    // drop this area
                    area_next  = area_reg + 1'b1;
                    state_next = pica_pkg::ST_AREA;
                end
                else
                begin
                    sign_next  = xp_stat.neg;
                    edge0_next = 1'b0;
                    if (closing_reg)
                    begin
                        found_next = 1'b1;
                        state_next = pica_pkg::ST_DONE;
                    end
                    else if (vidx_last)
                    begin
                        closing_next = 1'b1;
                        state_next   = pica_pkg::ST_MUL_A;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = pica_pkg::ST_FETCH;
                    end
                end
            end
            pica_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    hit_next     = found_reg;
                    state_next   = pica_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pica_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/pica_checker.sv =====
//------------------------------------------------------------------------------
// pica_checker
// Port-level checks for point_in_convex_areas, bound to the top level.
//------------------------------------------------------------------------------
`include "point_in_convex_areas_macros.svh"

module pica_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pica_pkg::M_TDATA_W-1:0] m_tdata
);

    `PICA_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result transaction dropped or changed while stalled")
    `PICA_ASSERT(a_test_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == pica_pkg::KIND_TEST) |=> !s_tready, "input still ready after a test transaction")
    `PICA_ASSERT(a_load_ready, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == pica_pkg::KIND_LOAD) |=> s_tready, "input not ready after a load transaction")
    `PICA_ASSERT_IMP(a_result_src, clk, rst_n, $rose(m_tvalid), $past(!s_tready), "result appeared without a test in progress")

endmodule

bind point_in_convex_areas pica_checker u_pica_checker (.*);

// ===== tb/pica_hit_checker.sv =====
//------------------------------------------------------------------------------
// pica_hit_checker
// Watches the vertex/point input stream, the area_count write channel and the
// hit output stream of point_in_convex_areas. Keeps its own vertex store and
// area counts, predicts the hit flag of every point test with exact edge cross
// products, and compares each output transaction with the oldest prediction.
//------------------------------------------------------------------------------
module pica_hit_checker
    import pica_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   checked,
    output int                   hits
);

    localparam int NAREA = DEF_MAX_AREAS;
    localparam int NVERT = DEF_MAX_VERTICES;

    logic signed [IN_COORD_BITS-1:0] vx_mem [NAREA*NVERT];
    logic signed [IN_COORD_BITS-1:0] vy_mem [NAREA*NVERT];
    logic [COUNT_W-1:0]              vert_count [NAREA];
    logic [CFG_W-1:0]                active_areas;
    bit                              hit_expect_q [$];
    int                              err_cnt;
    int                              n_checked;
    int                              n_hits;

    function automatic logic signed [35:0] edge_cross(
        input logic signed [15:0] ax,
        input logic signed [15:0] ay,
        input logic signed [15:0] bx,
        input logic signed [15:0] by,
        input logic signed [15:0] px,
        input logic signed [15:0] py
    );
        logic signed [16:0] ex;
        logic signed [16:0] ey;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        ex = 17'(bx) - 17'(ax);
        ey = 17'(by) - 17'(ay);
        dx = 17'(px) - 17'(ax);
        dy = 17'(py) - 17'(ay);
        return 36'(ex) * 36'(dy) - 36'(ey) * 36'(dx);
    endfunction

    function automatic bit point_in_area(
        input int                 area,
        input logic signed [15:0] px,
        input logic signed [15:0] py
    );
        int                 n;
        int                 base;
        int                 k;
        logic signed [35:0] cr;
        bit                 first_neg;
        n    = int'(vert_count[area]);
        base = area * NVERT;
        if (n < MIN_VERTS || n > NVERT)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            k  = (i + 1 == n) ? 0 : i + 1;
            cr = edge_cross(vx_mem[base+i], vy_mem[base+i],
                            vx_mem[base+k], vy_mem[base+k], px, py);
            if (cr == 0)
                return 1'b0;
            if (i == 0)
                first_neg = cr < 0;
            else if ((cr < 0) != first_neg)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_hit(
        input logic signed [15:0] px,
        input logic signed [15:0] py
    );
        int nact;
        nact = (int'(active_areas) > NAREA) ? NAREA : int'(active_areas);
        for (int j = 0; j < nact; j++)
        begin
            if (point_in_area(j, px, py))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [AREA_IDX_BITS-1:0]        a_idx;
        logic [VERT_IDX_BITS-1:0]        v_idx;
        logic signed [IN_COORD_BITS-1:0] cx;
        logic signed [IN_COORD_BITS-1:0] cy;
        bit                              exp_hit;
        if (!rst_n)
        begin
            for (int i = 0; i < NAREA; i++)
                vert_count[i] = '0;
            for (int i = 0; i < NAREA*NVERT; i++)
            begin
                vx_mem[i] = '0;
                vy_mem[i] = '0;
            end
            active_areas = '0;
            hit_expect_q.delete();
            err_cnt   = 0;
            n_checked = 0;
            n_hits    = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
            hits    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_areas = cfg_data;

            if (m_tvalid && m_tready)
            begin
                if (hit_expect_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("[%0t] unexpected hit transaction: hit=%0b",
                                 $realtime, m_tdata[0]);
                    err_cnt++;
                end
                else
                begin
                    exp_hit = hit_expect_q.pop_front();
                    n_checked++;
                    if (m_tdata[0])
                        n_hits++;
                    if (m_tdata[0] !== exp_hit)
                    begin
                        if (err_cnt < 10)
                            $display("[%0t] hit mismatch on result %0d: expected %0b got %0b",
                                     $realtime, n_checked, exp_hit, m_tdata[0]);
                        err_cnt++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                a_idx = s_tdata[AREA_LSB +: AREA_IDX_BITS];
                v_idx = s_tdata[VERT_LSB +: VERT_IDX_BITS];
                cx    = s_tdata[X_LSB +: IN_COORD_BITS];
                cy    = s_tdata[Y_LSB +: IN_COORD_BITS];
                if (s_tuser[0] == KIND_LOAD)
                begin
                    if (a_idx < NAREA && v_idx < NVERT)
                    begin
                        vx_mem[a_idx*NVERT + v_idx] = cx;
                        vy_mem[a_idx*NVERT + v_idx] = cy;
                        if (s_tlast)
                            vert_count[a_idx] = COUNT_W'(32'(v_idx) + 1);
                    end
                end
                else
                begin
                    hit_expect_q.push_back(predict_hit(cx, cy));
                end
            end

            errors  <= err_cnt;
            pending <= hit_expect_q.size();
            checked <= n_checked;
            hits    <= n_hits;
        end
    end

endmodule

// ===== tb/testbench.sv =====
//------------------------------------------------------------------------------
// testbench
// Stimulus and verdict for point_in_convex_areas. Loads convex polygons of
// random size, center, radius and winding into the four areas, fires point
// tests inside, outside, on vertices and edges, adds stray vertex writes, and
// sets area_count between phases to 4, 0, 7, 1 and then random values. Both
// stream sides idle at random; one long output stall backs the block up.
// pica_hit_checker does all prediction and comparison.
//------------------------------------------------------------------------------
module testbench;
    import pica_pkg::*;

    localparam int  LIMIT      = 1500000;
    localparam int  SETTLE     = 400;
    localparam int  LONG_HOLD  = 3000;
    localparam int  NUM_PHASES = 10;
    localparam int  PHASE_LEN  = 105;
    localparam real PI         = 3.14159265358979;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int errors;
    int pending;
    int checked;
    int hits;

    int cycle_count = 0;
    int n_items     = 0;
    int n_loads     = 0;
    int n_tests     = 0;
    int n_cfg       = 0;
    bit no_idle     = 1'b0;
    bit stall_pending = 1'b0;

    bit          written [4][16];
    logic [15:0] tb_vx   [4][16];
    logic [15:0] tb_vy   [4][16];
    int          tb_cnt  [4];
    int          area_cx [4];
    int          area_cy [4];
    int          area_rad[4];

    point_in_convex_areas dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pica_hit_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .hits      (hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random back-pressure, one long hold on request
    initial
    begin
        int hold;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (stall_pending)
            begin
                stall_pending = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic logic [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic send_item(
        input logic        kind,
        input logic [1:0]  area,
        input logic [3:0]  vert,
        input logic        last,
        input logic [15:0] x,
        input logic [15:0] y
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {2'b00, y, x, vert, area};
        do @(posedge clk); while (!s_tready);
        n_items++;
        if (kind == KIND_LOAD)
            n_loads++;
        else
            n_tests++;
    endtask

    // drop the last mark when it would make a test read an unwritten vertex
    task automatic load_vertex(
        input int          area,
        input int          vert,
        input bit          last,
        input logic [15:0] x,
        input logic [15:0] y
    );
        bit safe;
        safe = 1'b1;
        for (int i = 0; i < vert; i++)
            if (!written[area][i])
                safe = 1'b0;
        if (!safe)
            last = 1'b0;
        written[area][vert] = 1'b1;
        tb_vx[area][vert] = x;
        tb_vy[area][vert] = y;
        if (last)
            tb_cnt[area] = vert + 1;
        send_item(KIND_LOAD, area[1:0], vert[3:0], last, x, y);
    endtask

    task automatic test_point(input logic [15:0] x, input logic [15:0] y);
        send_item(KIND_TEST, 2'd0, 4'd0, 1'b0, x, y);
    endtask

    task automatic write_area_count(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic load_polygon(input int area, input bit broken);
        int  n;
        int  stop;
        int  rad;
        int  cx;
        int  cy;
        int  sel;
        real ang;
        real dir;
        real ph;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            n = rand_between(1, 2);
        else if (sel < 7)
            n = rand_between(3, 6);
        else if (sel < 9)
            n = rand_between(7, 12);
        else
            n = rand_between(13, 16);
        sel = $urandom_range(0, 7);
        if (sel < 2)
            rad = rand_between(2, 40);
        else if (sel < 5)
            rad = rand_between(40, 2000);
        else if (sel < 7)
            rad = rand_between(2000, 16000);
        else
            rad = rand_between(30000, 32767);
        cx  = rand_between(-(32767 - rad), 32767 - rad);
        cy  = rand_between(-(32767 - rad), 32767 - rad);
        dir = $urandom_range(0, 1) ? 1.0 : -1.0;
        ph  = $urandom_range(0, 999) * 2.0 * PI / 1000.0;
        stop = broken ? rand_between(0, n - 1) : n;
        area_cx[area]  = cx;
        area_cy[area]  = cy;
        area_rad[area] = rad;
        for (int i = 0; i < stop; i++)
        begin
            ang = ph + dir * 2.0 * PI * i / n;
            load_vertex(area, i, (i == n - 1),
                        clamp16(cx + $rtoi(rad * $cos(ang))),
                        clamp16(cy + $rtoi(rad * $sin(ang))));
        end
    endtask

    task automatic test_near_area(input int area);
        int sel;
        int span;
        int v;
        int k;
        int n;
        sel = $urandom_range(0, 9);
        n   = tb_cnt[area];
        if (sel == 7 && n > 0)
        begin
            v = $urandom_range(0, n - 1);
            test_point(tb_vx[area][v], tb_vy[area][v]);
        end
        else if (sel == 8 && n > 1)
        begin
            v = $urandom_range(0, n - 1);
            k = (v + 1 == n) ? 0 : v + 1;
            test_point(clamp16((int'($signed(tb_vx[area][v])) + int'($signed(tb_vx[area][k]))) / 2),
                       clamp16((int'($signed(tb_vy[area][v])) + int'($signed(tb_vy[area][k]))) / 2));
        end
        else if (sel == 9)
        begin
            test_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
        else
        begin
            span = area_rad[area] + area_rad[area] / 4 + 2;
            test_point(clamp16(area_cx[area] + rand_between(-span, span)),
                       clamp16(area_cy[area] + rand_between(-span, span)));
        end
    endtask

    task automatic stray_load();
        load_vertex(int'($urandom_range(0, 3)), int'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int start;
        int act;
        logic [CFG_W-1:0] cfg_val;

        for (int a = 0; a < 4; a++)
        begin
            tb_cnt[a]   = 0;
            area_cx[a]  = 0;
            area_cy[a]  = 0;
            area_rad[a] = 100;
            for (int v = 0; v < 16; v++)
                written[a][v] = 1'b0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no areas active out of reset
        test_point(16'sd0, 16'sd0);
        // counter-clockwise square in area 0
        load_vertex(0, 0, 1'b0, -16'sd160, -16'sd160);
        load_vertex(0, 1, 1'b0,  16'sd160, -16'sd160);
        load_vertex(0, 2, 1'b0,  16'sd160,  16'sd160);
        load_vertex(0, 3, 1'b1, -16'sd160,  16'sd160);
        write_area_count(3'd1);
        test_point(16'sd0, 16'sd0);
        test_point(16'sd160, 16'sd0);
        test_point(16'sd160, 16'sd160);
        test_point(16'sd500, 16'sd0);
        // clockwise triangle spanning the coordinate extremes in area 1
        load_vertex(1, 0, 1'b0, 16'h8000, 16'h8000);
        load_vertex(1, 1, 1'b0, 16'h8000, 16'h7fff);
        load_vertex(1, 2, 1'b1, 16'h7fff, 16'h8000);
        // areas below three vertices in areas 2 and 3
        load_vertex(2, 0, 1'b0, 16'sd0, 16'sd0);
        load_vertex(2, 1, 1'b1, 16'sd100, 16'sd100);
        load_vertex(3, 0, 1'b1, 16'sd5, 16'sd5);
        write_area_count(3'd7);
        test_point(-16'sd30000, -16'sd30000);
        test_point(16'h7fff, 16'h7fff);
        test_point(16'h8000, 16'h8000);
        test_point(16'sd0, 16'sd0);
        test_point(16'sd50, 16'sd50);
        write_area_count(3'd4);
        test_point(16'sd1, -16'sd1);

        for (int a = 0; a < 4; a++)
            load_polygon(a, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       cfg_val = 3'd4;
                1:       cfg_val = 3'd0;
                2:       cfg_val = 3'd7;
                3:       cfg_val = 3'd1;
                default: cfg_val = $urandom_range(0, 1) ? 3'd4 : 3'($urandom_range(0, 7));
            endcase
            write_area_count(cfg_val);
            no_idle = (p % 3 == 1);
            if (p == 2)
                stall_pending = 1'b1;
            start = n_items;
            while (n_items - start < PHASE_LEN)
            begin
                act = $urandom_range(0, 99);
                if (act < 20)
                    load_polygon($urandom_range(0, 3), 1'b0);
                else if (act < 24)
                    load_polygon($urandom_range(0, 3), 1'b1);
                else if (act < 90)
                    test_near_area($urandom_range(0, 3));
                else
                    stray_load();
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d vertex loads and %0d point tests over %0d area_count writes.",
                 n_loads, n_tests, n_cfg);
        $display("%0d hit results checked, %0d of them inside an area, %0d mismatches.",
                 checked, hits, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pica_pkg.sv
design/pica_vstore.sv
design/pica_xprod.sv
design/point_in_convex_areas.sv
design/pica_checker.sv
tb/pica_hit_checker.sv
tb/testbench.sv
